/* sv/mmcfp_pkg.sv */
// Shared types and constants of the motor command frame packer.
`default_nettype none

package mmcfp_pkg;

	typedef logic [2:0] func_t;

	// Function codes of an incoming command.
	localparam func_t FUNC_MIT     = 3'd0;
	localparam func_t FUNC_ENABLE  = 3'd1;
	localparam func_t FUNC_DISABLE = 3'd2;
	localparam func_t FUNC_ZERO    = 3'd3;
	localparam func_t FUNC_CLEAR   = 3'd4;

	// Command bytes placed in the last payload byte of a command frame.
	localparam logic [7:0] CMD_ENABLE  = 8'hFC;
	localparam logic [7:0] CMD_DISABLE = 8'hFD;
	localparam logic [7:0] CMD_ZERO    = 8'hFE;
	localparam logic [7:0] CMD_CLEAR   = 8'hFB;
	localparam logic [7:0] CMD_NONE    = 8'hFF;

	// Setpoint limits in their fixed-point units.
	localparam int POS_LIM = 25600;
	localparam int VEL_LIM = 20480;
	localparam int KP_LIM  = 32000;
	localparam int KD_LIM  = 20480;
	localparam int TRQ_LIM = 28672;

	// Scale factors imax / range, reduced to lowest terms.
	// Where the reduced denominator is a power of two the scaling is a multiply and shift.
	localparam int VEL_NUM   = 819;
	localparam int VEL_SHIFT = 13;
	localparam int KD_NUM    = 819;
	localparam int KD_SHIFT  = 12;
	localparam int TRQ_NUM   = 585;
	localparam int TRQ_SHIFT = 13;

	// Otherwise a rounded-up reciprocal with 2**SHIFT above (largest offset * denominator)
	// gives the exact floor for every offset in range.
	localparam int POS_NUM   = 13107;
	localparam int POS_DEN   = 10240;
	localparam int POS_SHIFT = 29;
	localparam logic [29:0] POS_MUL = 30'((64'(POS_NUM) * (64'd1 << POS_SHIFT)
		+ 64'(POS_DEN) - 64'd1) / 64'(POS_DEN));

	localparam int KP_NUM   = 819;
	localparam int KP_DEN   = 6400;
	localparam int KP_SHIFT = 28;
	localparam logic [25:0] KP_MUL = 26'((64'(KP_NUM) * (64'd1 << KP_SHIFT)
		+ 64'(KP_DEN) - 64'd1) / 64'(KP_DEN));

	// Scaled setpoint codes of one MIT control frame.
	typedef struct packed {
		logic [15:0] pos;
		logic [11:0] vel;
		logic [11:0] kp;
		logic [11:0] kd;
		logic [11:0] trq;
	} mit_codes_t;

endpackage

`default_nettype wire

/* sv/mit_motor_command_frame_packer_core.sv */
// Top level of the MIT-mode motor command frame packer.
//
// Each input transaction carries one motor command; each output transaction
// carries the CAN frame built from it: the identifier and the eight payload
// bytes split into a high and a low word. Function 0 clamps and scales the five
// setpoints into position, velocity, kp, kd and torque codes; the other
// functions give a command frame of 0xFF bytes ending in the command byte.
//
// A transaction accepted at a clock edge is captured in the input register; the
// finished frame is then loaded into the output register, from which the receiver
// takes it. Throughput is one transaction per cycle while the receiver does not
// stall; the scaling multipliers sit between the input and output registers and
// are used once per item.
//
// While the receiver stalls, the output register holds its frame and the input
// register can still take one more transaction; only when both are full is
// in_stall raised. Reset clears both valid flags, so the block comes out of reset
// empty and ready to accept.
`default_nettype none

module mit_motor_command_frame_packer_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  mmcfp_pkg::func_t      func,
	input  logic [10:0]           node_id,
	input  logic signed [15:0]    position,
	input  logic signed [15:0]    velocity,
	input  logic [15:0]           stiffness,
	input  logic [15:0]           damping,
	input  logic signed [15:0]    torque_ff,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [10:0]           frame_id,
	output logic [31:0]           payload_high,
	output logic [31:0]           payload_low
);
	import mmcfp_pkg::*;

	// Input register stage.
	logic               valid_s1;
	func_t              func_s1;
	logic [10:0]        node_id_s1;
	logic signed [15:0] position_s1;
	logic signed [15:0] velocity_s1;
	logic [15:0]        stiffness_s1;
	logic [15:0]        damping_s1;
	logic signed [15:0] torque_ff_s1;

	// Output register stage.
	logic               valid_s2;
	logic [10:0]        frame_id_s2;
	logic [31:0]        payload_high_s2;
	logic [31:0]        payload_low_s2;

	mit_codes_t         codes;
	logic [31:0]        frame_high;
	logic [31:0]        frame_low;
	logic               adv_s1;
	logic               adv_s2;

	// The output stage moves whenever it is empty or its frame is being taken;
	// the input stage moves whenever it is empty or can hand on to the output stage.
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			func_s1      <= func;
			node_id_s1   <= node_id;
			position_s1  <= position;
			velocity_s1  <= velocity;
			stiffness_s1 <= stiffness;
			damping_s1   <= damping;
			torque_ff_s1 <= torque_ff;
		end
	end

	mmcfp_scale u_scale (
		.position  (position_s1),
		.velocity  (velocity_s1),
		.stiffness (stiffness_s1),
		.damping   (damping_s1),
		.torque_ff (torque_ff_s1),
		.codes     (codes)
	);

	mmcfp_pack u_pack (
		.func         (func_s1),
		.codes        (codes),
		.payload_high (frame_high),
		.payload_low  (frame_low)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			frame_id_s2     <= node_id_s1;
			payload_high_s2 <= frame_high;
			payload_low_s2  <= frame_low;
		end
	end

	assign out_valid    = valid_s2;
	assign frame_id     = frame_id_s2;
	assign payload_high = payload_high_s2;
	assign payload_low  = payload_low_s2;

	// The block only pushes back when the input register already holds a command.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled while the input register is empty");

	// An accepted transaction is held in the input register at the next edge.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted transaction was not captured");

	// A command leaving the input register appears as an output frame.
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2) |=> out_valid)
		else $error("command lost between input and output registers");

	// The frame identifier is the motor identifier of the same command.
	a_frame_id: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2) |=> (frame_id == $past(node_id_s1)))
		else $error("frame identifier does not match the command");

endmodule

`default_nettype wire

/* sv/mmcfp_scale.sv */
// Clamping and fixed-point scaling of the five MIT control setpoints.
`default_nettype none

module mmcfp_scale (
	input  logic signed [15:0]  position,
	input  logic signed [15:0]  velocity,
	input  logic [15:0]         stiffness,
	input  logic [15:0]         damping,
	input  logic signed [15:0]  torque_ff,
	output mmcfp_pkg::mit_codes_t codes
);
	import mmcfp_pkg::*;

	logic signed [17:0] pos_sum;
	logic signed [17:0] vel_sum;
	logic signed [17:0] trq_sum;
	logic [15:0]        pos_off;
	logic [15:0]        vel_off;
	logic [14:0]        kp_off;
	logic [14:0]        kd_off;
	logic [15:0]        trq_off;
	logic [45:0]        pos_prod;
	logic [25:0]        vel_prod;
	logic [40:0]        kp_prod;
	logic [24:0]        kd_prod;
	logic [25:0]        trq_prod;

	// Offset the signed setpoints so that the lower limit sits at zero, then saturate.
	always_comb begin
		pos_sum = 18'(position) + 18'(POS_LIM);
		vel_sum = 18'(velocity) + 18'(VEL_LIM);
		trq_sum = 18'(torque_ff) + 18'(TRQ_LIM);

		if (pos_sum < 0) begin
			pos_off = '0;
		end else if (pos_sum > 18'(2 * POS_LIM)) begin
			pos_off = 16'(2 * POS_LIM);
		end else begin
			pos_off = pos_sum[15:0];
		end

		if (vel_sum < 0) begin
			vel_off = '0;
		end else if (vel_sum > 18'(2 * VEL_LIM)) begin
			vel_off = 16'(2 * VEL_LIM);
		end else begin
			vel_off = vel_sum[15:0];
		end

		if (trq_sum < 0) begin
			trq_off = '0;
		end else if (trq_sum > 18'(2 * TRQ_LIM)) begin
			trq_off = 16'(2 * TRQ_LIM);
		end else begin
			trq_off = trq_sum[15:0];
		end

		kp_off = (stiffness > 16'(KP_LIM)) ? 15'(KP_LIM) : stiffness[14:0];
		kd_off = (damping > 16'(KD_LIM)) ? 15'(KD_LIM) : damping[14:0];
	end

	assign pos_prod = 46'(pos_off) * 46'(POS_MUL);
	assign vel_prod = 26'(vel_off) * 26'(VEL_NUM);
	assign kp_prod  = 41'(kp_off) * 41'(KP_MUL);
	assign kd_prod  = 25'(kd_off) * 25'(KD_NUM);
	assign trq_prod = 26'(trq_off) * 26'(TRQ_NUM);

	assign codes.pos = pos_prod[POS_SHIFT +: 16];
	assign codes.vel = vel_prod[VEL_SHIFT +: 12];
	assign codes.kp  = kp_prod[KP_SHIFT +: 12];
	assign codes.kd  = kd_prod[KD_SHIFT +: 12];
	assign codes.trq = trq_prod[TRQ_SHIFT +: 12];

endmodule

`default_nettype wire

/* sv/mmcfp_pack.sv */
// Function decode and assembly of the eight payload bytes.
`default_nettype none

module mmcfp_pack (
	input  mmcfp_pkg::func_t      func,
	input  mmcfp_pkg::mit_codes_t codes,
	output logic [31:0]           payload_high,
	output logic [31:0]           payload_low
);
	import mmcfp_pkg::*;

	logic [7:0] cmd;

	always_comb begin
		unique case (func)
			FUNC_ENABLE:  cmd = CMD_ENABLE;
			FUNC_DISABLE: cmd = CMD_DISABLE;
			FUNC_ZERO:    cmd = CMD_ZERO;
			FUNC_CLEAR:   cmd = CMD_CLEAR;
			default:      cmd = CMD_NONE;
		endcase
	end

	// MIT frames pack position:16, velocity:12, kp:12, kd:12, torque:12, most significant first.
	always_comb begin
		if (func == FUNC_MIT) begin
			payload_high = {codes.pos, codes.vel, codes.kp[11:8]};
			payload_low  = {codes.kp[7:0], codes.kd, codes.trq};
		end else begin
			payload_high = '1;
			payload_low  = {24'hFF_FFFF, cmd};
		end
	end

endmodule

`default_nettype wire

/* sim/mit_motor_command_frame_packer_core_test.sv */
// Self-checking testbench of the MIT-mode motor command frame packer.
`timescale 1ns / 100ps

module mit_motor_command_frame_packer_core_test;
	import mmcfp_pkg::*;

	// Setpoint ranges and code ceilings, kept here on their own so that the
	// predicted frames do not lean on the block's own scaling constants.
	localparam int POSITION_LIMIT  = 25600;
	localparam int VELOCITY_LIMIT  = 20480;
	localparam int STIFFNESS_LIMIT = 32000;
	localparam int DAMPING_LIMIT   = 20480;
	localparam int TORQUE_LIMIT    = 28672;
	localparam int CODE16_MAX      = 65535;
	localparam int CODE12_MAX      = 4095;

	// Function codes past clear error have no command of their own; they give
	// an all-0xFF payload. This is the highest of them.
	localparam func_t FUNC_LAST        = 3'd7;

	// One motor command as it crosses the input handshake.
	typedef struct {
		func_t              func;
		logic [10:0]        node_id;
		logic signed [15:0] position;
		logic signed [15:0] velocity;
		logic [15:0]        stiffness;
		logic [15:0]        damping;
		logic signed [15:0] torque_ff;
	} motor_cmd_t;

	// One CAN frame as it leaves the block.
	typedef struct {
		logic [10:0] frame_id;
		logic [31:0] payload_high;
		logic [31:0] payload_low;
	} motor_frame_t;

	// The scoreboard turns every accepted command into the frame it should
	// give, queues it, and compares each frame leaving the block against the
	// oldest one still awaited. The block carries no state from one command to
	// the next, so each frame depends on its own command alone.
	class frame_scoreboard;
		motor_frame_t awaited[$];
		int unsigned  failures;
		int unsigned  commands_seen;
		int unsigned  mit_seen;
		int unsigned  frames_checked;
		int unsigned  deepest;

		// Only the first ten failures are written out; the rest are counted.
		function void flag(string what);
			failures++;
			if (failures <= 10) begin
				$display("MISMATCH at %0t: %s", $time, what);
			end
		endfunction

		// Saturate to [lo, hi], then floor((value - lo) * imax / (hi - lo)).
		function int unsigned scale_code(int value, int lo, int hi, int imax);
			longint offset;
			if (value < lo) value = lo;
			if (value > hi) value = hi;
			offset = longint'(value - lo);
			return int'((offset * longint'(imax)) / longint'(hi - lo));
		endfunction

		function motor_frame_t pack_frame(motor_cmd_t c);
			motor_frame_t f;
			logic [15:0]  pos_code;
			logic [11:0]  vel_code;
			logic [11:0]  kp_code;
			logic [11:0]  kd_code;
			logic [11:0]  trq_code;
			logic [7:0]   cmd_byte;
			f.frame_id = c.node_id;
			if (c.func == FUNC_MIT) begin
				pos_code = 16'(scale_code(int'(c.position), -POSITION_LIMIT,
					POSITION_LIMIT, CODE16_MAX));
				vel_code = 12'(scale_code(int'(c.velocity), -VELOCITY_LIMIT,
					VELOCITY_LIMIT, CODE12_MAX));
				kp_code = 12'(scale_code(int'(c.stiffness), 0, STIFFNESS_LIMIT,
					CODE12_MAX));
				kd_code = 12'(scale_code(int'(c.damping), 0, DAMPING_LIMIT,
					CODE12_MAX));
				trq_code = 12'(scale_code(int'(c.torque_ff), -TORQUE_LIMIT,
					TORQUE_LIMIT, CODE12_MAX));
				// Big-endian packing: position 16, velocity 12, kp 12, kd 12,
				// torque 12, with kp straddling the two words.
				f.payload_high = {pos_code, vel_code, kp_code[11:8]};
				f.payload_low  = {kp_code[7:0], kd_code, trq_code};
			end else begin
				case (c.func)
				FUNC_ENABLE:  cmd_byte = CMD_ENABLE;
				FUNC_DISABLE: cmd_byte = CMD_DISABLE;
				FUNC_ZERO:    cmd_byte = CMD_ZERO;
				FUNC_CLEAR:   cmd_byte = CMD_CLEAR;
				default:      cmd_byte = CMD_NONE;
				endcase
				f.payload_high = '1;
				f.payload_low  = {24'hFF_FFFF, cmd_byte};
			end
			return f;
		endfunction

		function void note_command(motor_cmd_t c);
			awaited.push_back(pack_frame(c));
			commands_seen++;
			if (c.func == FUNC_MIT) mit_seen++;
			if (awaited.size() > deepest) deepest = awaited.size();
		endfunction

		function void check_frame(motor_frame_t got);
			motor_frame_t want;
			if (awaited.size() == 0) begin
				flag($sformatf("frame id %03h hi %08h lo %08h with no command outstanding",
					got.frame_id, got.payload_high, got.payload_low));
				return;
			end
			want = awaited.pop_front();
			frames_checked++;
			if (got.frame_id !== want.frame_id || got.payload_high !== want.payload_high
				|| got.payload_low !== want.payload_low) begin
				flag($sformatf("expected id %03h hi %08h lo %08h, got id %03h hi %08h lo %08h",
					want.frame_id, want.payload_high, want.payload_low,
					got.frame_id, got.payload_high, got.payload_low));
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	func_t              func;
	logic [10:0]        node_id;
	logic signed [15:0] position;
	logic signed [15:0] velocity;
	logic [15:0]        stiffness;
	logic [15:0]        damping;
	logic signed [15:0] torque_ff;
	logic               out_valid;
	logic               out_stall;
	logic [10:0]        frame_id;
	logic [31:0]        payload_high;
	logic [31:0]        payload_low;

	frame_scoreboard sb;

	// Percentages of cycles in which each side holds back, set per phase.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	// Cycles for which the receiver must hold off regardless of its idle rate.
	int hold_left = 0;
	int unsigned held_cycles = 0;
	int unsigned input_held = 0;

	mit_motor_command_frame_packer_core DUT (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Generous fixed limit: the slowest phase needs well under a fifth of this.
	initial begin
		#2_000_000;
		$display("mit_motor_command_frame_packer_core_test: errors");
		$finish;
	end

	// Both handshakes are observed at the rising edge, before any register in
	// the block has moved. The input side is noted first so that a frame can
	// never be compared before the command that caused it has been queued.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				sb.note_command(motor_cmd_t'{func, node_id, position, velocity,
					stiffness, damping, torque_ff});
			end
			if (in_valid && in_stall) input_held++;
			if (out_valid && !out_stall) begin
				sb.check_frame(motor_frame_t'{frame_id, payload_high, payload_low});
			end
		end
	end

	// Receiver: decides at each falling edge whether to stall the next cycle.
	// A pending hold-off is counted down here, cycle by cycle, and takes
	// precedence over the random idling of the current phase.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
				held_cycles++;
			end else begin
				out_stall = ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Offers one transaction, entered and left at a falling edge. Idle cycles
	// come first; once valid is raised the payload stays put until the block
	// takes it.
	task automatic offer_command(input motor_cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		func      = c.func;
		node_id   = c.node_id;
		position  = c.position;
		velocity  = c.velocity;
		stiffness = c.stiffness;
		damping   = c.damping;
		torque_ff = c.torque_ff;
		in_valid  = 1'b1;
		do begin
			@(posedge clk);
		end while (in_stall);
		@(negedge clk);
	endtask

	task automatic offer_mit(input int id, input int p, input int v, input int kp,
		input int kd, input int t);
		offer_command(motor_cmd_t'{FUNC_MIT, 11'(id), 16'(p), 16'(v), 16'(kp),
			16'(kd), 16'(t)});
	endtask

	// Setpoint values weighted towards the interesting parts of the range:
	// mostly inside the limits, with a fair share of raw 16-bit noise, values
	// right at the saturation points, the field extremes and values near zero.
	function automatic logic [15:0] pick_setpoint(int limit, bit two_sided);
		int lo;
		int span;
		lo = two_sided ? -limit : 0;
		span = two_sided ? 2 * limit : limit;
		case ($urandom_range(9)) inside
		[0:4]: return 16'(int'($urandom_range(span)) + lo);
		[5:6]: return 16'($urandom);
		7: return 16'(($urandom_range(1) ? limit : lo) + int'($urandom_range(4)) - 2);
		8: begin
			if (two_sided) return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
			return $urandom_range(1) ? 16'h0000 : 16'hFFFF;
		end
		default: return 16'(int'($urandom_range(8)) - 4);
		endcase
	endfunction

	// A run of random commands under the given idling of both sides. About two
	// in three are MIT control transactions, since those exercise the scaling.
	task automatic run_phase(input int count, input int sender_idle,
		input int receiver_idle);
		motor_cmd_t c;
		send_idle_pct = sender_idle;
		recv_idle_pct = receiver_idle;
		repeat (count) begin
			if ($urandom_range(99) < 65) c.func = FUNC_MIT;
			else c.func = func_t'($urandom_range(FUNC_LAST, FUNC_ENABLE));
			c.node_id   = 11'($urandom);
			c.position  = pick_setpoint(POSITION_LIMIT, 1'b1);
			c.velocity  = pick_setpoint(VELOCITY_LIMIT, 1'b1);
			c.stiffness = pick_setpoint(STIFFNESS_LIMIT, 1'b0);
			c.damping   = pick_setpoint(DAMPING_LIMIT, 1'b0);
			c.torque_ff = pick_setpoint(TORQUE_LIMIT, 1'b1);
			offer_command(c);
		end
	endtask

	initial begin
		int f;
		in_valid  = 1'b0;
		func      = FUNC_MIT;
		node_id   = '0;
		position  = '0;
		velocity  = '0;
		stiffness = '0;
		damping   = '0;
		torque_ff = '0;
		arst_n    = 1'b0;
		sb = new();
		send_idle_pct = 25;
		recv_idle_pct = 74;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed MIT control transactions: the raw field extremes, each
		// setpoint exactly at its limits, one step outside (saturation), one
		// step inside, zero, minus one and an ordinary mid-range command.
		offer_mit(0, -32768, -32768, 0, 0, -32768);
		offer_mit(2047, 32767, 32767, 65535, 65535, 32767);
		offer_mit(11'h155, -POSITION_LIMIT, -VELOCITY_LIMIT, 0, 0, -TORQUE_LIMIT);
		offer_mit(11'h2AA, POSITION_LIMIT, VELOCITY_LIMIT, STIFFNESS_LIMIT,
			DAMPING_LIMIT, TORQUE_LIMIT);
		offer_mit(1, -POSITION_LIMIT - 1, -VELOCITY_LIMIT - 1, STIFFNESS_LIMIT + 1,
			DAMPING_LIMIT + 1, -TORQUE_LIMIT - 1);
		offer_mit(2, POSITION_LIMIT + 1, VELOCITY_LIMIT + 1, STIFFNESS_LIMIT + 1,
			DAMPING_LIMIT + 1, TORQUE_LIMIT + 1);
		offer_mit(3, POSITION_LIMIT - 1, VELOCITY_LIMIT - 1, STIFFNESS_LIMIT - 1,
			DAMPING_LIMIT - 1, TORQUE_LIMIT - 1);
		offer_mit(4, 1 - POSITION_LIMIT, 1 - VELOCITY_LIMIT, 1, 1, 1 - TORQUE_LIMIT);
		offer_mit(5, 0, 0, 0, 0, 0);
		offer_mit(6, -1, -1, 1, 1, -1);
		offer_mit(7, 12345, -9876, 16000, 10240, -14336);

		// Every command function, the spare codes among them, with random
		// setpoints that the block must ignore.
		for (f = FUNC_ENABLE; f <= FUNC_LAST; f++) begin
			offer_command(motor_cmd_t'{func_t'(f),
				(f == FUNC_ENABLE) ? 11'h7FF : 11'($urandom),
				16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom)});
		end

		// Back-pressure: the receiver holds off while the sender offers a
		// transaction every cycle, so both internal registers fill and the block
		// has to stall its input.
		hold_left = 60;
		run_phase(24, 0, 0);

		run_phase(470, 25, 74);
		run_phase(470, 74, 25);
		run_phase(470, 0, 0);
		in_valid = 1'b0;

		// Let every awaited frame arrive, then a few more cycles so that any
		// stray extra frame would still be caught.
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Run covered %0d commands (%0d MIT control), %0d frames compared.",
			sb.commands_seen, sb.mit_seen, sb.frames_checked);
		$display("Receiver held off %0d cycles, input stalled %0d cycles, backlog up to %0d.",
			held_cycles, input_held, sb.deepest);
		if (sb.failures == 0) begin
			$display("mit_motor_command_frame_packer_core_test: clean");
		end else begin
			$display("%0d failures in total.", sb.failures);
			$display("mit_motor_command_frame_packer_core_test: errors");
		end
		$finish;
	end

endmodule

/* files.f */
sv/mmcfp_pkg.sv
sv/mmcfp_scale.sv
sv/mmcfp_pack.sv
sv/mit_motor_command_frame_packer_core.sv
sim/mit_motor_command_frame_packer_core_test.sv
